### sv/gdfs_pkg.sv
// Shared constants for the depth-first traversal block.
package gdfs_pkg;
    localparam int MAX_NODES     = 32;
    localparam int STACK_ENTRIES = 1025;
    localparam int IDX_W         = $clog2(MAX_NODES);
    localparam int VTX_W         = 6;
    localparam int SADDR_W       = $clog2(STACK_ENTRIES);
    localparam int SDEPTH_W      = $clog2(STACK_ENTRIES + 1);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_EDGE  = 2'd1;
    localparam logic [1:0] CMD_DFS   = 2'd2;
    localparam logic [1:0] CMD_ALL   = 2'd3;
endpackage

### sv/gdfs_ram.sv
// Generic single write port, single read port RAM with registered read.
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/graph_depth_first_traversal.sv
// Depth-first traversal over an adjacency bit matrix held in RAM.
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one command beat:
//   clear, add edge, dfs from i_vertex_a, or traverse all components.
//   Output channel (o_out_valid/i_out_ready) returns one beat per visited
//   vertex in visit order; o_last_of_run marks the final beat of a command.
//   A dfs start outside 1..vertex_count (clamped to 32) gives one error beat (bad_start).
//   Config channel writes vertex_count; it is always ready. The user must
//   write it only while the block is idle; the block does not enforce this.
// Operation:
//   Clear drops the row valid bits. Add edge makes
//   two read-modify-write passes through the adjacency RAM.
//   A walk reads the row of each visited vertex, then scans its neighbors
//   with one stack push slot per cycle, and pops the stack for the next vertex.
//   One command is in flight at a time; o_in_ready is high only when idle.
// Reset: synchronous, active low; matrix reads as empty, vertex_count 32.
// Stall: each visit is held in a pending register so the last flag can be
//   set; the walk waits while the output register is full and not taken.
module graph_depth_first_traversal (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [5:0] i_vertex_a,
    input  logic [5:0] i_vertex_b,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_visited_vertex,
    output logic       o_tree_start,
    output logic       o_last_of_run,
    output logic       o_bad_start,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_vertex_count
);
    localparam int N = gdfs_pkg::MAX_NODES;
    localparam int IW = gdfs_pkg::IDX_W;
    localparam int VW = gdfs_pkg::VTX_W;
    localparam int AW = gdfs_pkg::SADDR_W;
    localparam int DW = gdfs_pkg::SDEPTH_W;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_EA   = 13'b0000000000010,
        ST_EAW  = 13'b0000000000100,
        ST_EB   = 13'b0000000001000,
        ST_EBW  = 13'b0000000010000,
        ST_ERR  = 13'b0000000100000,
        ST_NEXT = 13'b0000001000000,
        ST_POP  = 13'b0000010000000,
        ST_RD   = 13'b0000100000000,
        ST_VIS  = 13'b0001000000000,
        ST_ROW  = 13'b0010000000000,
        ST_PUSH = 13'b0100000000000,
        ST_FIN  = 13'b1000000000000
    } t_state;

    t_state        r_state;
    logic [VW-1:0] r_vcount;
    logic [1:0]    r_cmd;
    logic [IW-1:0] r_a, r_b, r_u, r_i;
    logic [VW-1:0] r_idx;
    logic [N-1:0]  r_row_valid, r_visited, r_reached, r_nb;
    logic [DW-1:0] r_depth;
    logic          r_first;
    logic          r_pend_v, r_pend_start;
    logic [IW-1:0] r_pend_u;
    logic          r_out_valid, r_out_start, r_out_last, r_out_bad;
    logic [VW-1:0] r_out_vertex;

    // active vertex count, clamped
    logic [VW-1:0] n_cnt;
    logic [N-1:0]  n_mask;
    logic          slot_free;
    logic          a_ok, b_ok;

    // adjacency RAM
    logic          adj_we;
    logic [IW-1:0] adj_waddr, adj_raddr;
    logic [N-1:0]  adj_wdata, adj_rdata, adj_row;
    // stack RAM
    logic          stk_we;
    logic [AW-1:0] stk_waddr, stk_raddr;
    logic [IW-1:0] stk_wdata, stk_rdata;

    assign n_cnt = (r_vcount > VW'(N)) ? VW'(N) : r_vcount;
    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_mask[k] = (VW'(k) < n_cnt);
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;
    assign a_ok = (i_vertex_a >= VW'(1)) && (i_vertex_a <= n_cnt);
    assign b_ok = (i_vertex_b >= VW'(1)) && (i_vertex_b <= n_cnt);

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_visited_vertex = r_out_vertex;
    assign o_tree_start     = r_out_start;
    assign o_last_of_run    = r_out_last;
    assign o_bad_start      = r_out_bad;

    // a row never written since clear reads as empty
    assign adj_row = r_row_valid[adj_raddr] ? adj_rdata : '0;

    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = r_a;
        adj_wdata = adj_row | (N'(1) << r_b);
        adj_raddr = r_u;
        unique case (r_state)
            ST_EA, ST_EAW: adj_raddr = r_a;
            ST_EB, ST_EBW: adj_raddr = r_b;
            default:       adj_raddr = r_u;
        endcase
        if (r_state == ST_EAW) begin
            adj_we = 1'b1;
        end else if (r_state == ST_EBW) begin
            adj_we    = 1'b1;
            adj_waddr = r_b;
            adj_wdata = adj_row | (N'(1) << r_a);
        end
    end

    // stack: seeded at entry 0 on walk start, pushed during the scan
    logic          walk_start;
    logic [IW-1:0] walk_vertex;
    always_comb begin
        walk_start  = 1'b0;
        walk_vertex = i_vertex_a[IW-1:0] - IW'(1);
        if (r_state == ST_IDLE && i_in_valid && i_cmd == gdfs_pkg::CMD_DFS && a_ok) begin
            walk_start = 1'b1;
        end else if (r_state == ST_NEXT && r_idx != n_cnt && !r_reached[r_idx[IW-1:0]]) begin
            walk_start  = 1'b1;
            walk_vertex = r_idx[IW-1:0];
        end
        stk_we    = walk_start;
        stk_waddr = '0;
        stk_wdata = walk_vertex;
        if (r_state == ST_PUSH && r_nb[r_i] &&
            r_depth < DW'(gdfs_pkg::STACK_ENTRIES)) begin
            stk_we    = 1'b1;
            stk_waddr = r_depth[AW-1:0];
            stk_wdata = r_i;
        end
        stk_raddr = AW'(r_depth - DW'(1));
    end

    gdfs_ram #(.WIDTH(N), .DEPTH(N)) u_adj (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    gdfs_ram #(.WIDTH(IW), .DEPTH(gdfs_pkg::STACK_ENTRIES)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vcount    <= VW'(N);
            r_row_valid <= '0;
            r_visited   <= '0;
            r_reached   <= '0;
            r_depth     <= '0;
            r_first     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_vertex_count;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (walk_start) begin
                r_visited <= '0;
                r_depth   <= DW'(1);
                r_first   <= 1'b1;
                r_state   <= ST_POP;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd <= i_cmd;
                        r_a   <= i_vertex_a[IW-1:0] - IW'(1);
                        r_b   <= i_vertex_b[IW-1:0] - IW'(1);
                        case (i_cmd)
                            gdfs_pkg::CMD_CLEAR: r_row_valid <= '0;
                            gdfs_pkg::CMD_EDGE: begin
                                if (a_ok && b_ok) begin
                                    r_state <= ST_EA;
                                end
                            end
                            gdfs_pkg::CMD_DFS: begin
                                if (!a_ok) begin
                                    r_state <= ST_ERR;
                                end
                            end
                            default: begin
                                r_reached <= '0;
                                r_idx     <= '0;
                                r_state   <= ST_NEXT;
                            end
                        endcase
                    end
                end
                ST_EA:  r_state <= ST_EAW;
                ST_EAW: begin
                    r_row_valid[r_a] <= 1'b1;
                    r_state          <= ST_EB;
                end
                ST_EB:  r_state <= ST_EBW;
                ST_EBW: begin
                    r_row_valid[r_b] <= 1'b1;
                    r_state          <= ST_IDLE;
                end
                ST_ERR: begin
                    if (slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_vertex <= '0;
                        r_out_start  <= 1'b0;
                        r_out_last   <= 1'b1;
                        r_out_bad    <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                ST_NEXT: begin
                    if (r_idx == n_cnt) begin
                        r_state <= ST_FIN;
                    end else if (r_reached[r_idx[IW-1:0]]) begin
                        r_idx <= r_idx + VW'(1);
                    end
                end
                ST_POP: begin
                    if (r_depth == '0) begin
                        if (r_cmd == gdfs_pkg::CMD_ALL) begin
                            r_idx   <= r_idx + VW'(1);
                            r_state <= ST_NEXT;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end else begin
                        r_depth <= r_depth - DW'(1);
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_u     <= stk_rdata;
                    r_state <= ST_VIS;
                end
                ST_VIS: begin
                    if (r_visited[r_u]) begin
                        r_state <= ST_POP;
                    end else if (!r_pend_v || slot_free) begin
                        if (r_pend_v) begin
                            r_out_valid  <= 1'b1;
                            r_out_vertex <= VW'(r_pend_u) + VW'(1);
                            r_out_start  <= r_pend_start;
                            r_out_last   <= 1'b0;
                            r_out_bad    <= 1'b0;
                        end
                        r_pend_v       <= 1'b1;
                        r_pend_u       <= r_u;
                        r_pend_start   <= r_first;
                        r_first        <= 1'b0;
                        r_visited[r_u] <= 1'b1;
                        r_reached[r_u] <= 1'b1;
                        r_state        <= ST_ROW;
                    end
                end
                ST_ROW: begin
                    r_nb    <= adj_row & n_mask & ~r_visited;
                    r_i     <= '0;
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (stk_we) begin
                        r_depth <= r_depth + DW'(1);
                    end
                    if (r_i == IW'(N - 1)) begin
                        r_state <= ST_POP;
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                ST_FIN: begin
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_vertex <= VW'(r_pend_u) + VW'(1);
                        r_out_start  <= r_pend_start;
                        r_out_last   <= 1'b1;
                        r_out_bad    <= 1'b0;
                        r_pend_v     <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

### sv/gdfs_checker.sv
// Port-level checks for the traversal block, bound to the top level.
module gdfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [5:0] o_visited_vertex,
    input logic       o_tree_start,
    input logic       o_last_of_run,
    input logic       o_bad_start
);
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_start |-> o_last_of_run && !o_tree_start &&
        o_visited_vertex == 6'd0)
        else $error("error beat malformed");

    a_vertex_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_start |-> o_visited_vertex != 6'd0)
        else $error("visit beat with vertex zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_visited_vertex)
        && $stable(o_last_of_run))
        else $error("stalled beat changed");

    a_start_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_of_run ##1 o_out_valid && !o_bad_start
        |-> o_tree_start)
        else $error("new run did not begin with a tree start");
endmodule

bind graph_depth_first_traversal gdfs_checker u_gdfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_visited_vertex(o_visited_vertex),
    .o_tree_start    (o_tree_start),
    .o_last_of_run   (o_last_of_run),
    .o_bad_start     (o_bad_start)
);

### tb/graph_depth_first_traversal_tb.sv
// Self-checking testbench for the depth-first traversal block.
module graph_depth_first_traversal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Pass/fail budget: a full walk can be long, so allow plenty.
    localparam int RESULT_CAP = 32;
    localparam int DRAIN_CYCLES = 6000;

    typedef struct packed {
        logic [5:0] vtx;
        logic       tree_start;
        logic       last;
        logic       bad;
    } t_visit;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_cmd = gdfs_pkg::CMD_CLEAR;
    logic [5:0] i_vertex_a = '0;
    logic [5:0] i_vertex_b = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [5:0] o_visited_vertex;
    logic       o_tree_start;
    logic       o_last_of_run;
    logic       o_bad_start;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_vertex_count = '0;

    graph_depth_first_traversal uut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow copy of the block state.
    logic [31:0] adj_rows [gdfs_pkg::MAX_NODES];
    logic [31:0] seen_walk;
    logic [31:0] seen_all;
    logic [5:0]  vcount;
    t_visit      visits_due[$];
    int          n_emit;
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    task automatic report(input string what, input logic [8:0] got, input logic [8:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic int nverts();
        return (vcount > gdfs_pkg::MAX_NODES) ? gdfs_pkg::MAX_NODES : int'(vcount);
    endfunction

    function automatic void push_visit(input logic [5:0] v, input logic ts, input logic bad);
        t_visit r;
        if (n_emit >= RESULT_CAP) return;
        r.vtx = v; r.tree_start = ts; r.last = 1'b0; r.bad = bad;
        visits_due = {visits_due, r};
        n_emit++;
    endfunction

    // Stack walk; duplicates are skipped on pop, pushes go ascending.
    function automatic void dfs_walk(input int start, input int n);
        int stk[$];
        int u;
        logic first;
        logic [31:0] nb;
        first = 1'b1;
        seen_walk = '0;
        stk = {stk, start};
        while (stk.size() > 0) begin
            u = stk.pop_back();
            if (seen_walk[u-1]) continue;
            seen_walk[u-1] = 1'b1;
            seen_all[u-1] = 1'b1;
            push_visit(6'(u), first, 1'b0);
            first = 1'b0;
            nb = adj_rows[u-1] & ~seen_walk;
            for (int i = 0; i < n; i++)
                if (nb[i] && stk.size() < gdfs_pkg::STACK_ENTRIES) stk = {stk, i + 1};
        end
    endfunction

    function automatic void predict_cmd(input logic [1:0] cmd, input logic [5:0] a,
                                        input logic [5:0] b);
        int n;
        int base;
        n = nverts();
        base = visits_due.size();
        n_emit = 0;
        case (cmd)
            gdfs_pkg::CMD_CLEAR: begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
            end
            gdfs_pkg::CMD_EDGE: begin
                if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                    adj_rows[a-1][b-1] = 1'b1;
                    adj_rows[b-1][a-1] = 1'b1;
                end
            end
            gdfs_pkg::CMD_DFS: begin
                if (a < 1 || a > n) push_visit(6'd0, 1'b0, 1'b1);
                else dfs_walk(int'(a), n);
            end
            default: begin
                seen_all = '0;
                for (int i = 1; i <= n; i++)
                    if (!seen_all[i-1]) dfs_walk(i, n);
            end
        endcase
        if (visits_due.size() > base) visits_due[$].last = 1'b1;
    endfunction

    // Send one command beat; prediction is made at acceptance.
    // Valid stays up after acceptance; idling or waiting drops it.
    task automatic send_cmd(input logic [1:0] cmd, input logic [5:0] a, input logic [5:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_vertex_a <= a;
        i_vertex_b <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_cmd(cmd, a, b);
        beats_in++;
    endtask

    // Wait for all results, then a pause for the edge/clear cycles.
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (visits_due.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [5:0] c);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_vertex_count <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        vcount = c;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: random stalls, compare each beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_visit w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (visits_due.size() == 0) begin
                report("unexpected beat", {o_visited_vertex, o_tree_start,
                       o_last_of_run, o_bad_start}, '0);
            end else begin
                w = visits_due.pop_front();
                if (o_visited_vertex !== w.vtx) report("vertex", 9'(o_visited_vertex), 9'(w.vtx));
                if (o_tree_start !== w.tree_start) report("tree_start", 9'(o_tree_start),
                    9'(w.tree_start));
                if (o_last_of_run !== w.last) report("last", 9'(o_last_of_run), 9'(w.last));
                if (o_bad_start !== w.bad) report("bad_start", 9'(o_bad_start), 9'(w.bad));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        send_cmd(gdfs_pkg::CMD_ALL, 6'd0, 6'd0);    // empty graph: 32 single trees
        send_cmd(gdfs_pkg::CMD_DFS, 6'd0, 6'd0);    // bad start, low
        send_cmd(gdfs_pkg::CMD_DFS, 6'd33, 6'd0);   // bad start, high
        send_cmd(gdfs_pkg::CMD_DFS, 6'd63, 6'd0);
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd1, 6'd32);
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd1, 6'd2);
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd2, 6'd3);
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd3, 6'd3);   // self loop
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd0, 6'd5);   // dropped
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd5, 6'd63);  // dropped
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd32, 6'd31);
        send_cmd(gdfs_pkg::CMD_DFS, 6'd1, 6'd42);
        send_cmd(gdfs_pkg::CMD_DFS, 6'd32, 6'd0);
        send_cmd(gdfs_pkg::CMD_ALL, 6'd0, 6'd63);
        // Pressure: hold off until the block drained everything.
        wait_idle();
        for (int v = 2; v <= 32; v++) send_cmd(gdfs_pkg::CMD_EDGE, 6'd1, 6'(v));
        send_cmd(gdfs_pkg::CMD_DFS, 6'd17, 6'd0);   // star: big stack
        send_cmd(gdfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
        send_cmd(gdfs_pkg::CMD_DFS, 6'd5, 6'd0);
    endtask

    task automatic test_counts();
        set_count(6'd0);                         // no vertices
        send_cmd(gdfs_pkg::CMD_ALL, 6'd0, 6'd0);
        send_cmd(gdfs_pkg::CMD_DFS, 6'd1, 6'd0);
        set_count(6'd63);                        // clamps to 32
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd4, 6'd30);
        send_cmd(gdfs_pkg::CMD_DFS, 6'd30, 6'd0);
        set_count(6'd1);
        send_cmd(gdfs_pkg::CMD_ALL, 6'd0, 6'd0);
        send_cmd(gdfs_pkg::CMD_DFS, 6'd2, 6'd0);
        set_count(6'd5);                         // edge to 30 now hidden
        send_cmd(gdfs_pkg::CMD_EDGE, 6'd4, 6'd5);
        send_cmd(gdfs_pkg::CMD_ALL, 6'd0, 6'd0);
    endtask

    // Mostly adds edges and walks the graph; some noise commands mixed in.
    task automatic test_random(input int items);
        int k;
        int n;
        k = 0;
        while (k < items) begin
            n = nverts();
            case ($urandom_range(9))
                0: send_cmd(gdfs_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom));
                1, 2: send_cmd(gdfs_pkg::CMD_DFS, 6'($urandom_range(n + 1)), 6'($urandom));
                3: send_cmd(gdfs_pkg::CMD_ALL, 6'($urandom), 6'($urandom));
                4: send_cmd(gdfs_pkg::CMD_EDGE, 6'($urandom), 6'($urandom));
                5: send_cmd(gdfs_pkg::CMD_DFS, 6'($urandom), 6'($urandom));
                default: send_cmd(gdfs_pkg::CMD_EDGE, 6'($urandom_range(n > 0 ? n : 1, 1)),
                                  6'($urandom_range(n > 0 ? n : 1, 1)));
            endcase
            k++;
        end
    endtask

    initial begin
        vcount = 6'd32;
        foreach (adj_rows[i]) adj_rows[i] = '0;
        seen_walk = '0;
        seen_all = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 19; recv_idle_pct = 53;
        test_directed();
        test_counts();
        set_count(6'd32);
        test_random(30);
        send_idle_pct = 53; recv_idle_pct = 19;
        set_count(6'd12);
        test_random(30);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_count(6'd32);
        test_random(35);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (visits_due.size() > 0) begin
            errors++;
            $display("%0d expected beats never arrived", visits_due.size());
        end
        $display("covered %0d commands and %0d result beats over counts 0..63",
                 beats_in, beats_out);
        if (errors == 0) begin
            $display("[graph_depth_first_traversal] OK");
        end else begin
            $display("[graph_depth_first_traversal] ERROR");
        end
        $finish;
    end

    initial begin
        #(12ns * 3000000);
        $display("[graph_depth_first_traversal] ERROR");
        $finish;
    end
endmodule
